### src/dtm_pkg.sv
// ----------------------------------------------------------------------------
// dtm_pkg
// Shared types and constants of the differential thrust mixer: word layouts
// of both channels, register indexes, pump codes and mixing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dtm_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLEW_LIMIT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PUMP_TIMEOUT = 1'b1;

  localparam logic [8:0] SLEW_LIMIT_RST = 9'd80;
  localparam logic [9:0] PUMP_TIMEOUT_RST = 10'd200;

  // input word kinds
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // pump modes
  localparam logic [1:0] PUMP_STOP = 2'd0;
  localparam logic [1:0] PUMP_RISE = 2'd1;
  localparam logic [1:0] PUMP_DIVE = 2'd2;

  // stick thresholds
  localparam logic [7:0] DRIVE_FWD_START = 8'd135;
  localparam logic [7:0] DRIVE_BACK_START = 8'd125;
  localparam logic [7:0] TURN_RIGHT_START = 8'd135;
  localparam logic [7:0] TURN_LEFT_START = 8'd115;
  localparam logic [7:0] VERT_RISE_ABOVE = 8'd129;
  localparam logic [7:0] VERT_DIVE_BELOW = 8'd121;
  localparam logic [7:0] VERT_RST = 8'd124;

  // pulse limits in microseconds
  localparam int PULSE_MIN = 1000;
  localparam int PULSE_MAX = 2000;
  localparam int PULSE_MID = 1500;

  // reciprocals for the constant divisions: n/6, n/3 and n/23
  localparam logic [15:0] RECIP_6 = 16'd43691;   // 2^18 / 6, rounded up
  localparam int RECIP_6_SHIFT = 18;
  localparam logic [14:0] RECIP_3 = 15'd21846;   // 2^16 / 3, rounded up
  localparam int RECIP_3_SHIFT = 16;
  localparam logic [15:0] RECIP_23 = 16'd45591;  // 2^20 / 23, rounded up
  localparam int RECIP_23_SHIFT = 20;

  localparam logic [9:0] ELAPSED_MAX = 10'd1023;

  typedef struct packed {
    logic       kind;
    logic [7:0] stick_turn;
    logic [7:0] stick_drive;
    logic [7:0] stick_vertical;
    logic       light_switch;
  } in_word_t;

  typedef struct packed {
    logic [10:0] left_pulse_us;
    logic [10:0] right_pulse_us;
    logic [1:0]  pump_mode;
    logic        light_on;
  } out_word_t;

endpackage

`default_nettype wire

### src/differential_thrust_mixer.sv
// ----------------------------------------------------------------------------
// differential_thrust_mixer
// Two-motor tank mixing with slew limit, light toggle and pump timer.
//
// Input words carry either a control step (sticks and light switch) or a
// one millisecond tick, selected by kind. Every input word yields exactly one
// result word: both committed motor pulses, the pump mode and the light.
// A word passes through the input register, where the mixing logic works on
// it, and then the result register. Throughput is one word per cycle while
// the receiver does not stall; the state update for a word completes as the
// word is mixed into the result register, so words follow back to back.
// When the receiver stalls the result register holds its word, the input
// register fills and then in_stall rises until the result is taken.
// Reset clears all state: pulses read 0 until the first step, the light is
// off, the pump is stopped, slew_limit is 80 and pump_timeout_ms is 200.
// Configuration writes apply at once; only the user keeps them to idle times.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_thrust_mixer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire dtm_pkg::in_word_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output dtm_pkg::out_word_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [dtm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [dtm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration
  logic [8:0] slew_limit_r;
  logic [9:0] pump_timeout_r;

  // pipeline
  logic               in_valid_r;
  dtm_pkg::in_word_t  in_data_r;
  logic               out_valid_r;
  dtm_pkg::out_word_t out_data_r;
  logic               advance;
  logic               in_take;

  // block state
  logic [10:0] last_left_r, last_left_nxt;
  logic [10:0] last_right_r, last_right_nxt;
  logic [1:0]  switch_hist_r, switch_hist_nxt;
  logic        light_r, light_nxt;
  logic [7:0]  last_vert_r, last_vert_nxt;
  logic [1:0]  pump_state_r, pump_state_nxt;
  logic        rise_r, rise_nxt;
  logic        dive_r, dive_nxt;
  logic        stop_done_r, stop_done_nxt;
  logic [9:0]  elapsed_r, elapsed_nxt;

  // mixing datapath
  logic [6:0]  drive_fwd_d;
  logic [6:0]  drive_back_d;
  logic [11:0] drive_fwd_n;
  logic [27:0] drive_fwd_prod;
  logic [6:0]  turn_right_d;
  logic [6:0]  turn_left_d;
  logic [10:0] turn_right_n;
  logic [13:0] turn_left_n;
  logic [25:0] turn_right_prod;
  logic [29:0] turn_left_prod;
  logic signed [12:0] base_s;
  logic signed [12:0] delta_s;
  logic signed [12:0] want_left_s;
  logic signed [12:0] want_right_s;
  logic        due;

  function automatic logic [10:0] limit_motor(logic signed [12:0] want,
                                              logic [10:0] prev,
                                              logic [8:0] lim);
    logic signed [12:0] p;
    logic signed [12:0] l;
    logic signed [12:0] diff;
    logic signed [12:0] v;
    p = $signed({2'b00, prev});
    l = $signed({4'b0000, lim});
    diff = want - p;
    if (diff > l) begin
      v = p + l;
    end else if (diff < -l) begin
      v = p - l;
    end else begin
      v = want;
    end
    if (v > 13'(dtm_pkg::PULSE_MAX)) begin
      v = 13'(dtm_pkg::PULSE_MAX);
    end
    if (v < 13'(dtm_pkg::PULSE_MIN)) begin
      v = 13'(dtm_pkg::PULSE_MIN);
    end
    return v[10:0];
  endfunction

  // handshake
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // drive stick to base pulse
  always_comb begin
    drive_fwd_d    = 7'(in_data_r.stick_drive - dtm_pkg::DRIVE_FWD_START);
    drive_back_d   = 7'(dtm_pkg::DRIVE_BACK_START - in_data_r.stick_drive);
    drive_fwd_n    = 12'(drive_fwd_d) * 12'd25;
    drive_fwd_prod = 28'(drive_fwd_n) * 28'(dtm_pkg::RECIP_6);
    if (in_data_r.stick_drive > dtm_pkg::DRIVE_FWD_START - 8'd1) begin
      base_s = 13'(dtm_pkg::PULSE_MID)
               - $signed({3'b000, drive_fwd_prod[dtm_pkg::RECIP_6_SHIFT +: 10]});
    end else if (in_data_r.stick_drive < dtm_pkg::DRIVE_BACK_START + 8'd1) begin
      // back maps exactly: 500/125 is four
      base_s = 13'(dtm_pkg::PULSE_MID) + $signed({4'b0000, drive_back_d, 2'b00});
    end else begin
      base_s = 13'(dtm_pkg::PULSE_MID);
    end
  end

  // turn stick to differential offset, positive adds to the left motor
  always_comb begin
    turn_right_d    = 7'(in_data_r.stick_turn - dtm_pkg::TURN_RIGHT_START);
    turn_left_d     = 7'(dtm_pkg::TURN_LEFT_START - in_data_r.stick_turn);
    turn_right_n    = 11'(turn_right_d) * 11'd10;
    turn_left_n     = 14'(turn_left_d) * 14'd80;
    turn_right_prod = 26'(turn_right_n) * 26'(dtm_pkg::RECIP_3);
    turn_left_prod  = 30'(turn_left_n) * 30'(dtm_pkg::RECIP_23);
    if (in_data_r.stick_turn > dtm_pkg::TURN_RIGHT_START - 8'd1) begin
      delta_s = $signed({4'b0000, turn_right_prod[dtm_pkg::RECIP_3_SHIFT +: 9]});
    end else if (in_data_r.stick_turn < dtm_pkg::TURN_LEFT_START + 8'd1) begin
      delta_s = -$signed({4'b0000, turn_left_prod[dtm_pkg::RECIP_23_SHIFT +: 9]});
    end else begin
      delta_s = '0;
    end
    want_left_s  = base_s + delta_s;
    want_right_s = base_s - delta_s;
  end

  // state update for the word in the input register
  always_comb begin
    last_left_nxt   = last_left_r;
    last_right_nxt  = last_right_r;
    switch_hist_nxt = switch_hist_r;
    light_nxt       = light_r;
    last_vert_nxt   = last_vert_r;
    pump_state_nxt  = pump_state_r;
    rise_nxt        = rise_r;
    dive_nxt        = dive_r;
    stop_done_nxt   = stop_done_r;
    elapsed_nxt     = elapsed_r;

    if (in_data_r.kind == dtm_pkg::KIND_STEP) begin
      // light toggles after three equal switch samples
      if (!in_data_r.light_switch && switch_hist_r == 2'b00 && !light_r) begin
        light_nxt = 1'b1;
      end else if (in_data_r.light_switch && switch_hist_r == 2'b11 && light_r) begin
        light_nxt = 1'b0;
      end
      switch_hist_nxt = {switch_hist_r[0], in_data_r.light_switch};

      last_left_nxt  = limit_motor(want_left_s, last_left_r, slew_limit_r);
      last_right_nxt = limit_motor(want_right_s, last_right_r, slew_limit_r);

      // pump command needs two agreeing samples
      if (last_vert_r > dtm_pkg::VERT_RISE_ABOVE
          && in_data_r.stick_vertical > dtm_pkg::VERT_RISE_ABOVE) begin
        pump_state_nxt = dtm_pkg::PUMP_RISE;
        rise_nxt       = 1'b1;
        dive_nxt       = 1'b0;
        stop_done_nxt  = 1'b0;
        elapsed_nxt    = '0;
      end else if (last_vert_r < dtm_pkg::VERT_DIVE_BELOW
                   && in_data_r.stick_vertical < dtm_pkg::VERT_DIVE_BELOW) begin
        pump_state_nxt = dtm_pkg::PUMP_DIVE;
        dive_nxt       = 1'b1;
        rise_nxt       = 1'b0;
        stop_done_nxt  = 1'b0;
        elapsed_nxt    = '0;
      end
      last_vert_nxt = in_data_r.stick_vertical;
    end else begin
      if (elapsed_r != dtm_pkg::ELAPSED_MAX) begin
        elapsed_nxt = elapsed_r + 10'd1;
      end
    end

    // stop check sees the state after this word
    due = (elapsed_nxt > pump_timeout_r) && !stop_done_nxt;
    if (rise_nxt) begin
      if (due) begin
        pump_state_nxt = dtm_pkg::PUMP_STOP;
        rise_nxt       = 1'b0;
        stop_done_nxt  = 1'b1;
      end
    end else if (dive_nxt) begin
      if (due) begin
        pump_state_nxt = dtm_pkg::PUMP_STOP;
        dive_nxt       = 1'b0;
        stop_done_nxt  = 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_limit_r   <= dtm_pkg::SLEW_LIMIT_RST;
      pump_timeout_r <= dtm_pkg::PUMP_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        dtm_pkg::CFG_SLEW_LIMIT:   slew_limit_r   <= cfg_wdata[8:0];
        dtm_pkg::CFG_PUMP_TIMEOUT: pump_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.left_pulse_us  <= last_left_nxt;
      out_data_r.right_pulse_us <= last_right_nxt;
      out_data_r.pump_mode      <= pump_state_nxt;
      out_data_r.light_on       <= light_nxt;
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_left_r   <= '0;
      last_right_r  <= '0;
      switch_hist_r <= 2'b11;
      light_r       <= 1'b0;
      last_vert_r   <= dtm_pkg::VERT_RST;
      pump_state_r  <= dtm_pkg::PUMP_STOP;
      rise_r        <= 1'b0;
      dive_r        <= 1'b0;
      stop_done_r   <= 1'b0;
      elapsed_r     <= '0;
    end else if (advance) begin
      last_left_r   <= last_left_nxt;
      last_right_r  <= last_right_nxt;
      switch_hist_r <= switch_hist_nxt;
      light_r       <= light_nxt;
      last_vert_r   <= last_vert_nxt;
      pump_state_r  <= pump_state_nxt;
      rise_r        <= rise_nxt;
      dive_r        <= dive_nxt;
      stop_done_r   <= stop_done_nxt;
      elapsed_r     <= elapsed_nxt;
    end
  end

  // rise and dive are never driven together
  a_pump_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rise_r && dive_r))
    else $error("rise and dive both active");

  // pump mode agrees with the active flags
  a_pump_mode_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (pump_state_r == dtm_pkg::PUMP_STOP) == !(rise_r || dive_r))
    else $error("pump mode disagrees with active flags");

  // once a step has been taken the left pulse stays within the motor range
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_left_r == 11'd0
    || (last_left_r >= 11'(dtm_pkg::PULSE_MIN) && last_left_r <= 11'(dtm_pkg::PULSE_MAX)))
    else $error("left pulse out of range");

  // a word held in the input register while the result stalls stays put
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(in_data_r))
    else $error("input register lost a stalled word");

  // the mixing stage only fires into a free or draining result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !advance)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### tb/tb_differential_thrust_mixer.sv
// ----------------------------------------------------------------------------
// tb_differential_thrust_mixer
// Self-checking bench for the two-motor mixer. A scoreboard works out the
// expected result word of every accepted input word and compares each result
// as it leaves. Stimulus runs a directed pass over stick extremes, deadband
// edges, pump commands and light toggles, then random words under six
// register settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_differential_thrust_mixer;

  localparam int TURN_SPAN = 400;
  localparam int PHASES = 6;
  localparam int RANDOM_PER_PHASE = 35;

  typedef enum int {ZONE_RISE, ZONE_DIVE, ZONE_IDLE} vert_zone_t;

  class mixer_scoreboard;
    logic [8:0]  slew;
    logic [9:0]  tout;
    logic [10:0] left_us;
    logic [10:0] right_us;
    logic [1:0]  sw_hist;
    logic        light;
    logic [7:0]  last_vert;
    logic [1:0]  pump;
    logic        rise_on;
    logic        dive_on;
    logic        stopped;
    logic [9:0]  elapsed;
    dtm_pkg::out_word_t mix_results_q[$];
    int errors, checked, steps, ticks, pump_cmds, pump_stops, light_flips;

    function new();
      slew = dtm_pkg::SLEW_LIMIT_RST;
      tout = dtm_pkg::PUMP_TIMEOUT_RST;
      left_us = '0;
      right_us = '0;
      sw_hist = 2'b11;
      light = 1'b0;
      last_vert = dtm_pkg::VERT_RST;
      pump = dtm_pkg::PUMP_STOP;
      rise_on = 1'b0;
      dive_on = 1'b0;
      stopped = 1'b0;
      elapsed = '0;
      errors = 0;
      checked = 0;
      steps = 0;
      ticks = 0;
      pump_cmds = 0;
      pump_stops = 0;
      light_flips = 0;
    endfunction

    function void set_reg(logic [dtm_pkg::CFG_ADDR_W-1:0] addr,
                          logic [dtm_pkg::CFG_DATA_W-1:0] data);
      if (addr == dtm_pkg::CFG_SLEW_LIMIT) slew = data[8:0];
      else if (addr == dtm_pkg::CFG_PUMP_TIMEOUT) tout = data[9:0];
    endfunction

    function int slew_clamp(int want, int prev);
      int lim;
      lim = int'(slew);
      if (want - prev > lim) want = prev + lim;
      else if (want - prev < -lim) want = prev - lim;
      if (want > dtm_pkg::PULSE_MAX) want = dtm_pkg::PULSE_MAX;
      if (want < dtm_pkg::PULSE_MIN) want = dtm_pkg::PULSE_MIN;
      return want;
    endfunction

    function void mix_word(dtm_pkg::in_word_t w);
      int base, l, r, delta, d, t;
      logic newer, older;
      dtm_pkg::out_word_t e;
      if (w.kind == dtm_pkg::KIND_STEP) begin
        steps++;
        newer = sw_hist[0];
        older = sw_hist[1];
        // light needs three equal samples, the new one and two held
        if (!w.light_switch && !newer && !older && !light) begin
          light = 1'b1;
          light_flips++;
        end else if (w.light_switch && newer && older && light) begin
          light = 1'b0;
          light_flips++;
        end
        sw_hist = {newer, w.light_switch};

        d = int'(w.stick_drive);
        t = int'(w.stick_turn);
        if (d >= int'(dtm_pkg::DRIVE_FWD_START))
          base = dtm_pkg::PULSE_MID - (d - int'(dtm_pkg::DRIVE_FWD_START)) * 500 / 120;
        else if (d <= int'(dtm_pkg::DRIVE_BACK_START))
          base = dtm_pkg::PULSE_MID + (int'(dtm_pkg::DRIVE_BACK_START) - d) * 500 / 125;
        else
          base = dtm_pkg::PULSE_MID;
        l = base;
        r = base;
        if (t >= int'(dtm_pkg::TURN_RIGHT_START)) begin
          delta = (t - int'(dtm_pkg::TURN_RIGHT_START)) * TURN_SPAN / 120;
          l += delta;
          r -= delta;
        end else if (t <= int'(dtm_pkg::TURN_LEFT_START)) begin
          delta = (int'(dtm_pkg::TURN_LEFT_START) - t) * TURN_SPAN / 115;
          l -= delta;
          r += delta;
        end
        left_us = 11'(slew_clamp(l, int'(left_us)));
        right_us = 11'(slew_clamp(r, int'(right_us)));

        if (last_vert > dtm_pkg::VERT_RISE_ABOVE
            && w.stick_vertical > dtm_pkg::VERT_RISE_ABOVE) begin
          pump = dtm_pkg::PUMP_RISE;
          rise_on = 1'b1;
          dive_on = 1'b0;
          stopped = 1'b0;
          elapsed = '0;
          pump_cmds++;
        end else if (last_vert < dtm_pkg::VERT_DIVE_BELOW
                     && w.stick_vertical < dtm_pkg::VERT_DIVE_BELOW) begin
          pump = dtm_pkg::PUMP_DIVE;
          dive_on = 1'b1;
          rise_on = 1'b0;
          stopped = 1'b0;
          elapsed = '0;
          pump_cmds++;
        end
        last_vert = w.stick_vertical;
      end else begin
        ticks++;
        if (elapsed < dtm_pkg::ELAPSED_MAX) elapsed++;
      end

      // timeout check follows every word, step or tick
      if ((rise_on || dive_on) && !stopped && elapsed > tout) begin
        pump = dtm_pkg::PUMP_STOP;
        rise_on = 1'b0;
        dive_on = 1'b0;
        stopped = 1'b1;
        pump_stops++;
      end

      e.left_pulse_us = left_us;
      e.right_pulse_us = right_us;
      e.pump_mode = pump;
      e.light_on = light;
      mix_results_q.push_back(e);
    endfunction

    function void check_word(dtm_pkg::out_word_t got);
      dtm_pkg::out_word_t e;
      if (mix_results_q.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        errors++;
        return;
      end
      e = mix_results_q.pop_front();
      checked++;
      if (got.left_pulse_us !== e.left_pulse_us) begin
        $error("left_pulse_us: expected %0d, got %0d", e.left_pulse_us, got.left_pulse_us);
        errors++;
      end
      if (got.right_pulse_us !== e.right_pulse_us) begin
        $error("right_pulse_us: expected %0d, got %0d", e.right_pulse_us, got.right_pulse_us);
        errors++;
      end
      if (got.pump_mode !== e.pump_mode) begin
        $error("pump_mode: expected %0d, got %0d", e.pump_mode, got.pump_mode);
        errors++;
      end
      if (got.light_on !== e.light_on) begin
        $error("light_on: expected %0d, got %0d", e.light_on, got.light_on);
        errors++;
      end
    endfunction

    function int pending();
      return mix_results_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  dtm_pkg::in_word_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  dtm_pkg::out_word_t             out_data;
  logic                           cfg_we = 1'b0;
  logic [dtm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [dtm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  mixer_scoreboard sb = new();

  // stimulus state
  int         tx_idle_pct = 30;
  int         rx_stall_pct = 30;
  int         cur_tout = int'(dtm_pkg::PUMP_TIMEOUT_RST);
  logic [7:0] last_turn = 8'd127;
  logic [7:0] last_drive = 8'd127;
  vert_zone_t vert_zone = ZONE_IDLE;
  logic       sw_level = 1'b1;
  logic [7:0] stick_edges [14] = '{8'd0, 8'd1, 8'd115, 8'd116, 8'd117, 8'd125, 8'd126,
                                   8'd127, 8'd133, 8'd134, 8'd135, 8'd136, 8'd254, 8'd255};

  differential_thrust_mixer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.mix_word(in_data);
      if (out_valid && !out_stall) sb.check_word(out_data);
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return $urandom_range(20, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 15;
      2: return 40;
      default: return 75;
    endcase
  endfunction

  // receiver stalls in runs
  initial begin
    wait (rst_n);
    forever begin
      if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic dtm_pkg::in_word_t mk_step(logic [7:0] t, logic [7:0] d,
                                                logic [7:0] v, logic sw);
    dtm_pkg::in_word_t w;
    w.kind = dtm_pkg::KIND_STEP;
    w.stick_turn = t;
    w.stick_drive = d;
    w.stick_vertical = v;
    w.light_switch = sw;
    return w;
  endfunction

  // stick and switch fields of a tick carry junk, the block ignores them
  function automatic dtm_pkg::in_word_t mk_tick();
    dtm_pkg::in_word_t w;
    w.kind = dtm_pkg::KIND_TICK;
    w.stick_turn = 8'($urandom());
    w.stick_drive = 8'($urandom());
    w.stick_vertical = 8'($urandom());
    w.light_switch = 1'($urandom());
    return w;
  endfunction

  function automatic dtm_pkg::in_word_t noise_step();
    return mk_step(8'($urandom()), 8'($urandom()), 8'($urandom()), 1'($urandom()));
  endfunction

  function automatic logic [7:0] pick_stick(logic [7:0] prev);
    int v;
    case ($urandom_range(2))
      0: v = $urandom_range(255);
      1: v = int'(stick_edges[$urandom_range(13)]);
      default: begin
        v = int'(prev) + int'($urandom_range(24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
    endcase
    return 8'(v);
  endfunction

  // vertical stick lingers in one zone so that pairs agree and commands land
  function automatic logic [7:0] pick_vertical();
    if ($urandom_range(4) == 0) vert_zone = vert_zone_t'($urandom_range(2));
    case (vert_zone)
      ZONE_RISE: return ($urandom_range(7) == 0) ? 8'd130 : 8'($urandom_range(255, 130));
      ZONE_DIVE: return ($urandom_range(7) == 0) ? 8'd120 : 8'($urandom_range(120, 0));
      default:   return 8'($urandom_range(129, 121));
    endcase
  endfunction

  function automatic dtm_pkg::in_word_t next_step();
    if ($urandom_range(6) == 0) sw_level = ~sw_level;
    last_turn = pick_stick(last_turn);
    last_drive = pick_stick(last_drive);
    return mk_step(last_turn, last_drive, pick_vertical(), sw_level);
  endfunction

  task automatic send_word(input dtm_pkg::in_word_t w);
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // hold the sender until every outstanding result word has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dtm_pkg::CFG_ADDR_W-1:0] addr, input int value);
    cfg_addr <= addr;
    cfg_wdata <= dtm_pkg::CFG_DATA_W'(value);
    cfg_we <= 1'b1;
    @(posedge clk);
    sb.set_reg(addr, dtm_pkg::CFG_DATA_W'(value));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic tick_burst(input int count);
    repeat (count) send_word(mk_tick());
  endtask

  task automatic run_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        tx_idle_pct = pick_idle_pct();
        rx_stall_pct = pick_idle_pct();
      end
      r = $urandom_range(99);
      if (r < 3)
        tick_burst($urandom_range((cur_tout + 4 > 20) ? 20 : cur_tout + 4, 1));
      else if (r < 38)
        send_word(mk_tick());
      else if (r < 46)
        send_word(noise_step());
      else
        send_word(next_step());
      if ($urandom_range(199) == 0) settle();
    end
  endtask

  initial begin
    int slew_tab [PHASES];
    int tout_tab [PHASES];
    slew_tab = '{80, 1, 500, 0, 511, 0};
    tout_tab = '{200, 3, 1023, 0, 1, 0};
    slew_tab[5] = $urandom_range(500, 1);
    tout_tab[5] = $urandom_range(60, 1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first step from zero, stick extremes and deadband edges,
    // light on and off, rise and dive commands and their near misses
    send_word(mk_step(8'd127, 8'd127, 8'd124, 1'b1));
    send_word(mk_step(8'd0, 8'd255, 8'd255, 1'b0));
    send_word(mk_step(8'd255, 8'd0, 8'd255, 1'b0));
    send_word(mk_step(8'd115, 8'd135, 8'd0, 1'b0));
    send_word(mk_step(8'd116, 8'd134, 8'd0, 1'b1));
    send_word(mk_step(8'd134, 8'd126, 8'd130, 1'b1));
    send_word(mk_step(8'd135, 8'd125, 8'd130, 1'b1));
    send_word(mk_step(8'd255, 8'd255, 8'd129, 1'b0));
    send_word(mk_step(8'd0, 8'd0, 8'd129, 1'b0));
    send_word(mk_step(8'd128, 8'd0, 8'd121, 1'b0));
    send_word(mk_step(8'd128, 8'd255, 8'd121, 1'b1));
    send_word(mk_step(8'd128, 8'd128, 8'd120, 1'b1));
    send_word(mk_step(8'd128, 8'd128, 8'd120, 1'b1));
    send_word(mk_tick());
    send_word(mk_tick());
    send_word(mk_step(8'd117, 8'd133, 8'd200, 1'b0));
    send_word(mk_step(8'd136, 8'd124, 8'd201, 1'b0));
    send_word(mk_tick());
    send_word(mk_step(8'd1, 8'd254, 8'd124, 1'b0));
    send_word(mk_step(8'd254, 8'd1, 8'd124, 1'b1));

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p > 0) begin
        write_reg(dtm_pkg::CFG_SLEW_LIMIT, slew_tab[p]);
        write_reg(dtm_pkg::CFG_PUMP_TIMEOUT, tout_tab[p]);
        cur_tout = tout_tab[p];
      end
      // phase three sends its opening words with no idling on either side
      tx_idle_pct = (p == 3) ? 0 : 30;
      rx_stall_pct = (p == 3) ? 0 : 30;
      // rise command, then ticks across the timeout (or into saturation)
      send_word(mk_step(8'($urandom()), 8'($urandom()), 8'd200, sw_level));
      send_word(mk_step(8'($urandom()), 8'($urandom()), 8'd220, sw_level));
      tick_burst((cur_tout + 3 > 1030) ? 1030 : cur_tout + 3);
      run_random(RANDOM_PER_PHASE);
    end

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d control steps and %0d ms ticks over %0d register settings",
             sb.steps, sb.ticks, PHASES);
    $display("%0d result words checked, %0d pump commands, %0d pump stops, %0d light changes",
             sb.checked, sb.pump_cmds, sb.pump_stops, sb.light_flips);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("differential_thrust_mixer verification clean");
    else
      $display("differential_thrust_mixer verification failed");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("differential_thrust_mixer verification failed");
    $finish;
  end

endmodule
